// ===== design/gpshb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpshb_pkg
// shared types, constants and the arctangent table for the home bearing block
// ----------------------------------------------------------------------------
package gpshb_pkg;

  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned SQRT_STEPS   = 30;

  localparam logic signed [33:0] COS_GAIN   = 34'sd652032874;
  localparam logic        [30:0] QTR_TURN   = 31'd900000000;
  localparam logic        [31:0] HALF_TURN  = 32'd1800000000;
  localparam logic        [31:0] FULL_TURN  = 32'd3600000000;
  localparam logic        [31:0] BEAR_ROUND = 32'd50000;
  localparam logic        [20:0] DM_Q24     = 21'd1867631;
  localparam logic        [26:0] RECIP_3125 = 27'd87960930;
  localparam logic        [11:0] DIV_3125   = 12'd3125;
  localparam logic        [15:0] BEAR_WRAP  = 16'd36000;
  localparam logic        [27:0] DIST_MAX   = 28'hFFFFFFF;
  localparam logic         [3:0] MIN_FIX_RST = 4'd3;
  localparam logic         [7:0] MIN_SAT_RST = 8'd7;

  localparam logic [0:0] REG_MIN_FIX = 1'b0;
  localparam logic [0:0] REG_MIN_SAT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_COS, ST_HOME, ST_DIFF, ST_MUL_E, ST_MUL_DN, ST_MUL_DE,
    ST_SQ_N, ST_SQ_E, ST_SUM, ST_SQRT, ST_NORM_LOAD, ST_NORM, ST_VEC,
    ST_QUAD, ST_MUL_Q, ST_MUL_R, ST_FIX, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_COS_ITER, OP_HOME, OP_DIFF, OP_MUL_E, OP_MUL_DN,
    OP_MUL_DE, OP_SQ_N, OP_SQ_E, OP_SUM, OP_SQRT_ITER, OP_NORM_LOAD,
    OP_NORM_ITER, OP_VEC_ITER, OP_QUAD, OP_MUL_Q, OP_MUL_R, OP_FIX, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] iter;
    logic       in_ready;
  } cmd_t;

  typedef struct packed {
    logic cap_now;
    logic nav_now;
    logic zero_vec;
    logic norm_big;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sd450000000;
      5'd1:    v = 32'sd265650512;
      5'd2:    v = 32'sd140362435;
      5'd3:    v = 32'sd71250163;
      5'd4:    v = 32'sd35763344;
      5'd5:    v = 32'sd17899106;
      5'd6:    v = 32'sd8951737;
      5'd7:    v = 32'sd4476142;
      5'd8:    v = 32'sd2238105;
      5'd9:    v = 32'sd1119057;
      5'd10:   v = 32'sd559529;
      5'd11:   v = 32'sd279765;
      5'd12:   v = 32'sd139882;
      5'd13:   v = 32'sd69941;
      5'd14:   v = 32'sd34971;
      5'd15:   v = 32'sd17485;
      5'd16:   v = 32'sd8743;
      5'd17:   v = 32'sd4371;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/gpshb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpshb_ctrl
// sequencer stepping the datapath through capture, offsets, sqrt and bearing
// ----------------------------------------------------------------------------
module gpshb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire gpshb_pkg::status_t sts,
  output gpshb_pkg::cmd_t        cmd
);

  gpshb_pkg::state_t state, state_next;
  logic [4:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpshb_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else cnt <= cnt + 5'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gpshb_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (sts.cap_now) state_next = gpshb_pkg::ST_COS;
          else if (sts.nav_now) state_next = gpshb_pkg::ST_DIFF;
          else state_next = gpshb_pkg::ST_EMIT;
        end
      end
      gpshb_pkg::ST_COS: begin
        if (cnt == 5'(gpshb_pkg::CORDIC_STEPS - 1)) state_next = gpshb_pkg::ST_HOME;
      end
      gpshb_pkg::ST_HOME:   state_next = gpshb_pkg::ST_DIFF;
      gpshb_pkg::ST_DIFF:   state_next = gpshb_pkg::ST_MUL_E;
      gpshb_pkg::ST_MUL_E:  state_next = gpshb_pkg::ST_MUL_DN;
      gpshb_pkg::ST_MUL_DN: state_next = gpshb_pkg::ST_MUL_DE;
      gpshb_pkg::ST_MUL_DE: state_next = gpshb_pkg::ST_SQ_N;
      gpshb_pkg::ST_SQ_N:   state_next = gpshb_pkg::ST_SQ_E;
      gpshb_pkg::ST_SQ_E:   state_next = gpshb_pkg::ST_SUM;
      gpshb_pkg::ST_SUM:    state_next = gpshb_pkg::ST_SQRT;
      gpshb_pkg::ST_SQRT: begin
        if (cnt == 5'(gpshb_pkg::SQRT_STEPS - 1)) state_next = gpshb_pkg::ST_NORM_LOAD;
      end
      gpshb_pkg::ST_NORM_LOAD: begin
        if (sts.zero_vec) state_next = gpshb_pkg::ST_QUAD;
        else state_next = gpshb_pkg::ST_NORM;
      end
      gpshb_pkg::ST_NORM: begin
        if (sts.norm_big) state_next = gpshb_pkg::ST_VEC;
      end
      gpshb_pkg::ST_VEC: begin
        if (cnt == 5'(gpshb_pkg::CORDIC_STEPS - 1)) state_next = gpshb_pkg::ST_QUAD;
      end
      gpshb_pkg::ST_QUAD:  state_next = gpshb_pkg::ST_MUL_Q;
      gpshb_pkg::ST_MUL_Q: state_next = gpshb_pkg::ST_MUL_R;
      gpshb_pkg::ST_MUL_R: state_next = gpshb_pkg::ST_FIX;
      gpshb_pkg::ST_FIX:   state_next = gpshb_pkg::ST_EMIT;
      gpshb_pkg::ST_EMIT: begin
        if (sts.out_free) state_next = gpshb_pkg::ST_IDLE;
      end
      default: state_next = gpshb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = gpshb_pkg::OP_NONE;
    cmd.iter     = cnt;
    cmd.in_ready = 1'b0;
    case (state)
      gpshb_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (s_tvalid) cmd.op = gpshb_pkg::OP_LOAD;
      end
      gpshb_pkg::ST_COS:       cmd.op = gpshb_pkg::OP_COS_ITER;
      gpshb_pkg::ST_HOME:      cmd.op = gpshb_pkg::OP_HOME;
      gpshb_pkg::ST_DIFF:      cmd.op = gpshb_pkg::OP_DIFF;
      gpshb_pkg::ST_MUL_E:     cmd.op = gpshb_pkg::OP_MUL_E;
      gpshb_pkg::ST_MUL_DN:    cmd.op = gpshb_pkg::OP_MUL_DN;
      gpshb_pkg::ST_MUL_DE:    cmd.op = gpshb_pkg::OP_MUL_DE;
      gpshb_pkg::ST_SQ_N:      cmd.op = gpshb_pkg::OP_SQ_N;
      gpshb_pkg::ST_SQ_E:      cmd.op = gpshb_pkg::OP_SQ_E;
      gpshb_pkg::ST_SUM:       cmd.op = gpshb_pkg::OP_SUM;
      gpshb_pkg::ST_SQRT:      cmd.op = gpshb_pkg::OP_SQRT_ITER;
      gpshb_pkg::ST_NORM_LOAD: cmd.op = gpshb_pkg::OP_NORM_LOAD;
      gpshb_pkg::ST_NORM: begin
        if (!sts.norm_big) cmd.op = gpshb_pkg::OP_NORM_ITER;
      end
      gpshb_pkg::ST_VEC:       cmd.op = gpshb_pkg::OP_VEC_ITER;
      gpshb_pkg::ST_QUAD:      cmd.op = gpshb_pkg::OP_QUAD;
      gpshb_pkg::ST_MUL_Q:     cmd.op = gpshb_pkg::OP_MUL_Q;
      gpshb_pkg::ST_MUL_R:     cmd.op = gpshb_pkg::OP_MUL_R;
      gpshb_pkg::ST_FIX:       cmd.op = gpshb_pkg::OP_FIX;
      gpshb_pkg::ST_EMIT: begin
        if (sts.out_free) cmd.op = gpshb_pkg::OP_EMIT;
      end
      default: cmd.op = gpshb_pkg::OP_NONE;
    endcase
  end

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    (state == gpshb_pkg::ST_COS || state == gpshb_pkg::ST_VEC)
      |-> cnt < 5'(gpshb_pkg::CORDIC_STEPS)) else $error("cordic count overrun");
  a_sqrt_range: assert property (@(posedge clk) disable iff (rst)
    state == gpshb_pkg::ST_SQRT |-> cnt < 5'(gpshb_pkg::SQRT_STEPS))
    else $error("sqrt count overrun");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> state == gpshb_pkg::ST_IDLE) else $error("ready outside idle");

endmodule
`default_nettype wire

// ===== design/gpshb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpshb_datapath
// home store, cordic units, shared multiplier, square root and output register
// ----------------------------------------------------------------------------
module gpshb_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gpshb_pkg::cmd_t    cmd,
  output gpshb_pkg::status_t      sts,
  input  wire logic               s_tvalid,
  input  wire logic [103:0]       s_tdata,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [87:0]             m_tdata,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);

  logic [3:0] min_fix;
  logic [7:0] min_sat;

  logic [3:0]         in_fix;
  logic [7:0]         in_sats;
  logic signed [30:0] in_lat;
  logic signed [31:0] in_lon;
  logic signed [27:0] in_alt;

  logic [3:0]         fix_r;
  logic [7:0]         sats_r;
  logic signed [30:0] lat_r;
  logic signed [31:0] lon_r;
  logic signed [27:0] alt_r;
  logic               nav_r;

  logic               home_flag;
  logic signed [30:0] home_lat;
  logic signed [31:0] home_lon;
  logic signed [27:0] home_alt;
  logic [16:0]        home_cos;

  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;

  logic [31:0] n_mag;
  logic [32:0] lon_mag;
  logic        dlat_neg, dlon_neg;
  logic [32:0] e_val;
  logic [28:0] dn, de;
  logic [59:0] sq_sum;

  logic [32:0] mul_a;
  logic [28:0] mul_b;
  logic [61:0] prod;

  logic [59:0] rem;
  logic [58:0] res;
  logic [58:0] sbit;

  logic signed [44:0] vx, vy;
  logic signed [32:0] vz;

  logic [26:0] u_div;
  logic [15:0] q0;

  logic [15:0] last_bearing;
  logic [27:0] last_distance;

  logic        good_fix;
  logic [30:0] lat_abs;
  logic signed [32:0] atan_x;
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic [59:0] sq_try;
  logic [29:0] ang;
  logic [31:0] full;
  logic [31:0] full_rnd;
  logic [26:0] r_div;
  logic [15:0] q_fix;
  logic signed [33:0] cos_rnd;
  logic [16:0] cos_q16;

  assign in_fix  = s_tdata[3:0];
  assign in_sats = s_tdata[11:4];
  assign in_lat  = s_tdata[42:12];
  assign in_lon  = s_tdata[74:43];
  assign in_alt  = s_tdata[102:75];

  assign good_fix    = in_fix >= min_fix;
  assign sts.cap_now = good_fix && (in_sats >= min_sat) && !home_flag;
  assign sts.nav_now = good_fix && (home_flag || sts.cap_now);
  assign sts.zero_vec = (n_mag == '0) && (e_val == '0);
  assign sts.norm_big = (vx[44:40] != '0) || (vy[44:40] != '0);
  assign sts.out_free = !m_tvalid || m_tready;

  assign lat_abs = in_lat[30] ? 31'(-in_lat) : in_lat;
  assign atan_x  = 33'(gpshb_pkg::atan_entry(cmd.iter));

  assign dlat = 32'(home_lat) - 32'(lat_r);
  assign dlon = 33'(home_lon) - 33'(lon_r);

  assign sq_try = rem - 60'(res) - 60'(sbit);

  assign cos_rnd = (cx + 34'sd8192) >>> 14;
  always_comb begin
    if (cos_rnd < 0) cos_q16 = '0;
    else if (cos_rnd > 34'sd65536) cos_q16 = 17'd65536;
    else cos_q16 = cos_rnd[16:0];
  end

  always_comb begin
    if (vz < 0) ang = '0;
    else if (vz > 33'(gpshb_pkg::QTR_TURN)) ang = 30'(gpshb_pkg::QTR_TURN);
    else ang = vz[29:0];
  end

  always_comb begin
    if (!dlon_neg) full = dlat_neg ? gpshb_pkg::HALF_TURN - 32'(ang) : 32'(ang);
    else full = dlat_neg ? gpshb_pkg::HALF_TURN + 32'(ang)
                         : gpshb_pkg::FULL_TURN - 32'(ang);
  end
  assign full_rnd = full + gpshb_pkg::BEAR_ROUND;

  assign r_div = u_div - prod[26:0];
  always_comb begin
    q_fix = q0 + ((r_div >= 27'(gpshb_pkg::DIV_3125)) ? 16'd1 : 16'd0);
    if (q_fix >= gpshb_pkg::BEAR_WRAP) q_fix = '0;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      gpshb_pkg::OP_MUL_E:  begin mul_a = lon_mag;      mul_b = 29'(home_cos); end
      gpshb_pkg::OP_MUL_DN: begin mul_a = 33'(n_mag);   mul_b = 29'(gpshb_pkg::DM_Q24); end
      gpshb_pkg::OP_MUL_DE: begin mul_a = e_val;        mul_b = 29'(gpshb_pkg::DM_Q24); end
      gpshb_pkg::OP_SQ_N:   begin mul_a = 33'(dn);      mul_b = dn; end
      gpshb_pkg::OP_SQ_E:   begin mul_a = 33'(de);      mul_b = de; end
      gpshb_pkg::OP_MUL_Q:  begin mul_a = 33'(u_div);   mul_b = 29'(gpshb_pkg::RECIP_3125); end
      gpshb_pkg::OP_MUL_R:  begin mul_a = 33'(prod[53:38]); mul_b = 29'(gpshb_pkg::DIV_3125); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_fix       <= gpshb_pkg::MIN_FIX_RST;
      min_sat       <= gpshb_pkg::MIN_SAT_RST;
      home_flag     <= 1'b0;
      home_lat      <= '0;
      home_lon      <= '0;
      home_alt      <= '0;
      home_cos      <= '0;
      last_bearing  <= '0;
      last_distance <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gpshb_pkg::REG_MIN_FIX: min_fix <= cfg_data[3:0];
          gpshb_pkg::REG_MIN_SAT: min_sat <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == gpshb_pkg::OP_EMIT) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (cmd.op)
        gpshb_pkg::OP_HOME: begin
          home_flag <= 1'b1;
          home_lat  <= lat_r;
          home_lon  <= lon_r;
          home_alt  <= alt_r;
          home_cos  <= cos_q16;
        end
        gpshb_pkg::OP_FIX: begin
          last_bearing  <= q_fix;
          last_distance <= (res > 59'(gpshb_pkg::DIST_MAX)) ? gpshb_pkg::DIST_MAX
                                                           : res[27:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      gpshb_pkg::OP_LOAD: begin
        fix_r  <= in_fix;
        sats_r <= in_sats;
        lat_r  <= in_lat;
        lon_r  <= in_lon;
        alt_r  <= in_alt;
        nav_r  <= sts.nav_now;
        cx     <= gpshb_pkg::COS_GAIN;
        cy     <= '0;
        cz     <= (lat_abs > gpshb_pkg::QTR_TURN) ? 33'(gpshb_pkg::QTR_TURN) : 33'(lat_abs);
      end
      gpshb_pkg::OP_COS_ITER: begin
        if (!cz[32]) begin
          cx <= cx - (cy >>> cmd.iter);
          cy <= cy + (cx >>> cmd.iter);
          cz <= cz - atan_x;
        end else begin
          cx <= cx + (cy >>> cmd.iter);
          cy <= cy - (cx >>> cmd.iter);
          cz <= cz + atan_x;
        end
      end
      gpshb_pkg::OP_DIFF: begin
        n_mag    <= dlat[31] ? 32'(-dlat) : 32'(dlat);
        lon_mag  <= dlon[32] ? 33'(-dlon) : 33'(dlon);
        dlat_neg <= dlat[31];
        dlon_neg <= dlon[32];
      end
      gpshb_pkg::OP_MUL_DN: e_val <= 33'((prod + 62'd32768) >> 16);
      gpshb_pkg::OP_MUL_DE: dn <= 29'((prod + 62'd8388608) >> 24);
      gpshb_pkg::OP_SQ_N:   de <= 29'((prod + 62'd8388608) >> 24);
      gpshb_pkg::OP_SQ_E:   sq_sum <= prod[59:0];
      gpshb_pkg::OP_SUM: begin
        rem  <= sq_sum + prod[59:0];
        res  <= '0;
        sbit <= 59'(1) << 58;
      end
      gpshb_pkg::OP_SQRT_ITER: begin
        if (rem >= 60'(res) + 60'(sbit)) begin
          rem <= sq_try;
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
      end
      gpshb_pkg::OP_NORM_LOAD: begin
        vx <= 45'(n_mag);
        vy <= 45'(e_val);
        vz <= '0;
      end
      gpshb_pkg::OP_NORM_ITER: begin
        vx <= vx <<< 1;
        vy <= vy <<< 1;
      end
      gpshb_pkg::OP_VEC_ITER: begin
        if (!vy[44] && (vy != '0)) begin
          vx <= vx + (vy >>> cmd.iter);
          vy <= vy - (vx >>> cmd.iter);
          vz <= vz + atan_x;
        end else begin
          vx <= vx - (vy >>> cmd.iter);
          vy <= vy + (vx >>> cmd.iter);
          vz <= vz - atan_x;
        end
      end
      gpshb_pkg::OP_QUAD:  u_div <= full_rnd[31:5];
      gpshb_pkg::OP_MUL_R: q0 <= prod[53:38];
      gpshb_pkg::OP_EMIT: begin
        m_tdata <= {2'b00, home_alt, last_distance, last_bearing, nav_r, home_flag,
                    sats_r, fix_r};
      end
      default: ;
    endcase
  end

  a_home_sticky: assert property (@(posedge clk) disable iff (rst)
    home_flag |=> home_flag) else $error("home flag dropped");
  a_nav_home: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[13] || m_tdata[12])) else $error("nav without home");
  a_bear_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[29:14] < gpshb_pkg::BEAR_WRAP) else $error("bearing out of range");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gpshb_pkg::OP_LOAD) |-> (s_tvalid && cmd.in_ready))
    else $error("load without transfer");

endmodule
`default_nettype wire

// ===== design/gps_home_bearing_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gps_home_bearing_distance
// bearing and equirectangular distance from each gps fix to a captured home
// ----------------------------------------------------------------------------
// One fix report enters on the s_ stream and exactly one result leaves on the
// m_ stream for each report. The first good fix with enough satellites becomes
// home; the cosine of its latitude is found by an 18 step cordic.
// Reports are handled one at a time by a sequencer over a shared multiplier,
// a bit-pair square root and an 18 step vectoring cordic.
// Steps from transfer to result:
//   no update: straight to the output register; capture: cosine cordic first
//   update: offsets, multiplies, square root, normalizing shifts, vectoring
//   cordic, quadrant and rounding; at home shifts and vectoring are skipped
// The next report is taken once the result sits in the output register; if
// the receiver stalls, the block holds the result, takes and works the next
// report and waits before emitting it.
// Reset clears home, the last bearing and distance and restores the minimum
// fix type 3 and satellite count 7. cfg_index 0 is the minimum fix type,
// 1 the minimum satellite count.
// ----------------------------------------------------------------------------
module gps_home_bearing_distance (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // fix_kind, satellites_seen, latitude, longitude, altitude, pad
  input  wire logic [103:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // fix_kind_out, satellites_out, home_held, nav_valid, home_bearing,
  // home_distance, home_altitude_out, pad
  output logic [87:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);

  gpshb_pkg::cmd_t    cmd;
  gpshb_pkg::status_t sts;

  assign s_tready = cmd.in_ready;

  gpshb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpshb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the gps home bearing and distance block
// ----------------------------------------------------------------------------
// Fix reports stream in with random gaps. A bit-level predictor of the home
// capture, latitude cosine, equirectangular distance and vectoring bearing
// computes each expected result. Every output transfer is compared field by
// field with the oldest prediction. The thresholds change between phases
// while the block is idle. Once, the receiver holds off for a long stretch so
// that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [3:0]  fix;
    logic [7:0]  sats;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [27:0] alt;
  } fix_report_t;

  typedef struct {
    logic [3:0]  fix;
    logic [7:0]  sats;
    logic        held;
    logic        nav;
    logic [15:0] bearing;
    logic [27:0] distance;
    logic [27:0] alt;
  } nav_result_t;

  localparam int CYCLE_LIMIT = 1000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;

  gps_home_bearing_distance uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fix_report_t pending_reports[$];
  nav_result_t expected_results[$];
  fix_report_t offered;
  bit          offering = 0;
  bit          in_xfer = 0;
  int          accepted_count = 0;
  int          hold_left = 0;
  bit          hold_done = 0;
  int          errors = 0;
  int          cycles = 0;

  // predictor state
  logic [3:0]  p_min_fix = 4'd3;
  logic [7:0]  p_min_sat = 8'd7;
  bit          p_home = 0;
  longint      p_home_lat = 0, p_home_lon = 0, p_home_alt = 0;
  longint      p_cos = 0;
  longint      p_bearing = 0, p_distance = 0;
  longint      home_lat_pick = -453217890;
  longint      home_lon_pick = 1203456789;

  function automatic longint atan_deg(int i);
    longint t[18] = '{450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
                      8951737, 4476142, 2238105, 1119057, 559529, 279765,
                      139882, 69941, 34971, 17485, 8743, 4371};
    return t[i];
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint z, x, y, dx, dy;
    z = lat < 0 ? -lat : lat;
    x = 652032874;
    y = 0;
    if (z > 900000000) z = 900000000;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_deg(i);
      end else begin
        x += dx; y -= dy; z += atan_deg(i);
      end
    end
    x = (x + 8192) >>> 14;
    if (x < 0) x = 0;
    if (x > 65536) x = 65536;
    return x;
  endfunction

  function automatic longint quadrant_angle(longint unsigned nx, longint unsigned ey);
    longint x, y, z, dx, dy;
    z = 0;
    if (nx == 0 && ey == 0) return 0;
    while (nx < (64'd1 << 40) && ey < (64'd1 << 40)) begin
      nx <<= 1;
      ey <<= 1;
    end
    x = nx;
    y = ey;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_deg(i);
      end else begin
        x -= dx; y += dy; z -= atan_deg(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 900000000) z = 900000000;
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n -= res + bt; res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic nav_result_t predict_nav(fix_report_t r);
    nav_result_t o;
    longint lat, lon, dlat, dlon, a, full;
    longint unsigned n, e, dn, de, d, b;
    bit good;
    lat = longint'($signed(r.lat));
    lon = longint'($signed(r.lon));
    good = r.fix >= p_min_fix;
    o.nav = 0;
    if (good && r.sats >= p_min_sat && !p_home) begin
      p_home = 1;
      p_home_lat = lat;
      p_home_lon = lon;
      p_home_alt = longint'($signed(r.alt));
      p_cos = lat_cosine(lat);
    end
    if (good && p_home) begin
      dlat = p_home_lat - lat;
      dlon = p_home_lon - lon;
      n = dlat < 0 ? -dlat : dlat;
      e = ((dlon < 0 ? -dlon : dlon) * p_cos + (64'd1 << 15)) >> 16;
      dn = (n * 1867631 + (64'd1 << 23)) >> 24;
      de = (e * 1867631 + (64'd1 << 23)) >> 24;
      d = int_sqrt(dn * dn + de * de);
      a = quadrant_angle(n, e);
      if (dlon >= 0) full = (dlat >= 0) ? a : 64'sd1800000000 - a;
      else full = (dlat >= 0) ? 64'sd3600000000 - a : 64'sd1800000000 + a;
      b = (full + 50000) / 100000;
      if (b >= 36000) b = 0;
      p_bearing = b;
      p_distance = d > 268435455 ? 268435455 : d;
      o.nav = 1;
    end
    o.fix = r.fix;
    o.sats = r.sats;
    o.held = p_home;
    o.bearing = p_bearing[15:0];
    o.distance = p_distance[27:0];
    o.alt = p_home_alt[27:0];
    return o;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic fix_report_t make_report(logic [3:0] fix, logic [7:0] sats,
                                              longint lat, longint lon, longint alt);
    fix_report_t r;
    r.fix = fix;
    r.sats = sats;
    r.lat = lat[30:0];
    r.lon = lon[31:0];
    r.alt = alt[27:0];
    return r;
  endfunction

  function automatic longint near_offset();
    int k;
    k = $urandom_range(0, 31);
    return longint'($signed($urandom)) >>> k;
  endfunction

  function automatic void queue_random(int count);
    logic [3:0] fix;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        fix = $urandom_range(0, 99) < 85 ? 4'($urandom_range(p_min_fix, 8)) : 4'($urandom);
        pending_reports.push_back(make_report(fix, 8'($urandom),
          home_lat_pick + near_offset(), home_lon_pick + near_offset(),
          longint'($signed(28'($urandom)))));
      end else begin
        pending_reports.push_back(make_report(4'($urandom), 8'($urandom),
          longint'($signed(31'($urandom))), longint'($signed($urandom)),
          longint'($signed(28'($urandom)))));
      end
    end
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gpshb_pkg::REG_MIN_FIX) p_min_fix = val[3:0];
    else p_min_sat = val;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0 || offering || expected_results.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // input transfers and prediction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(predict_nav(offered));
      accepted_count++;
      in_xfer = 1;
    end
  end

  // sender
  always @(negedge clk) begin
    bit quiet, next_valid;
    quiet = accepted_count >= 100 && accepted_count < 300;
    if (in_xfer) begin
      in_xfer = 0;
      offering = 0;
    end
    next_valid = offering;
    if (!rst && !offering && pending_reports.size() != 0 &&
        (quiet || $urandom_range(0, 99) >= 15)) begin
      offered = pending_reports.pop_front();
      offering = 1;
      next_valid = 1;
      s_tdata <= {1'b0, offered.alt, offered.lon, offered.lat, offered.sats, offered.fix};
    end
    s_tvalid <= next_valid;
  end

  // receiver
  always @(negedge clk) begin
    if (!hold_done && accepted_count >= 400) begin
      hold_done <= 1;
      hold_left <= 3000;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (accepted_count >= 100 && accepted_count < 300) ||
                  $urandom_range(0, 99) >= 15;
    end
  end

  // output transfers
  always @(posedge clk) begin
    nav_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("fix_kind_out", want.fix, m_tdata[3:0]);
        check_field("satellites_out", want.sats, m_tdata[11:4]);
        check_field("home_held", want.held, m_tdata[12]);
        check_field("nav_valid", want.nav, m_tdata[13]);
        check_field("home_bearing", want.bearing, m_tdata[29:14]);
        check_field("home_distance", want.distance, m_tdata[57:30]);
        check_field("home_altitude_out", want.alt, m_tdata[85:58]);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: no home yet, then capture and extremes around it
    pending_reports.push_back(make_report(4'd0, 8'd255, 900000000, 1800000000, 100000000));
    pending_reports.push_back(make_report(4'd2, 8'd20, 12345, -5, 0));
    pending_reports.push_back(make_report(4'd8, 8'd6, -900000000, -1800000000, -1000000));
    pending_reports.push_back(make_report(4'd3, 8'd7, home_lat_pick, home_lon_pick,
                                          -1000000));
    pending_reports.push_back(make_report(4'd3, 8'd0, home_lat_pick, home_lon_pick, 5));
    pending_reports.push_back(make_report(4'd2, 8'd255, 0, 0, 0));
    pending_reports.push_back(make_report(4'd8, 8'd255, 900000000, 1800000000, 100000000));
    pending_reports.push_back(make_report(4'd8, 8'd0, -900000000, -1800000000, -1000000));
    pending_reports.push_back(make_report(4'd4, 8'd1, 1073741823, 2147483647, 134217727));
    pending_reports.push_back(make_report(4'd15, 8'd9, -1073741824, -2147483648,
                                          -134217728));
    pending_reports.push_back(make_report(4'd3, 8'd9, home_lat_pick + 1000, home_lon_pick, 0));
    pending_reports.push_back(make_report(4'd3, 8'd9, home_lat_pick - 1000, home_lon_pick, 0));
    pending_reports.push_back(make_report(4'd3, 8'd9, home_lat_pick, home_lon_pick + 1000, 0));
    pending_reports.push_back(make_report(4'd3, 8'd9, home_lat_pick, home_lon_pick - 1000, 0));
    pending_reports.push_back(make_report(4'd5, 8'd9, home_lat_pick + 777, home_lon_pick - 777,
                                          0));
    pending_reports.push_back(make_report(4'd5, 8'd9, home_lat_pick - 1, home_lon_pick + 1, 0));
    pending_reports.push_back(make_report(4'd5, 8'd9, home_lat_pick, home_lon_pick, 0));
    wait_drained();

    write_reg(gpshb_pkg::REG_MIN_FIX, 8'd3);
    write_reg(gpshb_pkg::REG_MIN_SAT, 8'd7);
    queue_random(350);
    wait_drained();

    write_reg(gpshb_pkg::REG_MIN_FIX, 8'd0);
    write_reg(gpshb_pkg::REG_MIN_SAT, 8'd0);
    queue_random(200);
    wait_drained();

    write_reg(gpshb_pkg::REG_MIN_FIX, 8'd8);
    write_reg(gpshb_pkg::REG_MIN_SAT, 8'd255);
    queue_random(150);
    wait_drained();

    write_reg(gpshb_pkg::REG_MIN_FIX, 8'd2);
    write_reg(gpshb_pkg::REG_MIN_SAT, 8'd128);
    queue_random(150);
    wait_drained();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gpshb_pkg.sv
design/gpshb_ctrl.sv
design/gpshb_datapath.sv
design/gps_home_bearing_distance.sv
tb/testbench.sv
